/* rtl/cfc_pkg.sv */
// ----------------------------------------------------------------------------
// cfc_pkg: shared constants for the CRC-16 frame checker
// Header bytes, frame limits and the CRC polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

package cfc_pkg;

  // Frame layout.
  localparam int unsigned HEADER_LEN = 5;
  localparam logic [7:0]  HDR_BYTE0  = 8'hF8;
  localparam logic [7:0]  HDR_BYTE1  = 8'h55;
  localparam logic [7:0]  HDR_BYTE2  = 8'hCE;
  localparam logic [15:0] MIN_LEN    = 16'd7;
  localparam logic [15:0] POS_MAX    = 16'hFFFF;

  // CRC-16 with polynomial x^16 + x^12 + x^5 + 1.
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP_BIT = 16'h8000;

  // First position whose beat pushes a held byte into the CRC.
  localparam logic [15:0] CRC_START_POS = 16'(HEADER_LEN + 2);

endpackage

`default_nettype wire

/* rtl/crc16_frame_checker.sv */
// ----------------------------------------------------------------------------
// crc16_frame_checker: header and CRC-16 check of a byte-serial frame
// Registers each beat, updates the frame state and reports on the last byte.
// ----------------------------------------------------------------------------
// A last byte's beat passes the input register and then the result register;
// a stalled result register can hold it in the input register in between.
// Throughput: one byte per cycle unless the result stalls; the combinational
// byte-wide CRC update in the processing stage sets that figure.
// Reset: synchronous rst clears the frame state (header flag set) and both
// stage valids; the frame state also returns to reset after every last byte.
`default_nettype none

module crc16_frame_checker
  import cfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        data_valid,
  output logic             data_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             crc_ok,
  output logic             too_short,
  output logic             header_ok,
  output logic      [15:0] computed_crc
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Frame state.
  logic [15:0] crc_register;
  logic [7:0]  held0;
  logic [7:0]  held1;
  logic [15:0] byte_position;
  logic        header_match;

  logic        advance;
  logic        fire;
  logic [15:0] crc_fed;
  logic [15:0] crc_next;
  logic        header_next;
  logic        short_frame;

  // The processing stage moves whenever the result register is free.
  assign advance    = !result_valid || !result_stall;
  assign fire       = s1_valid && advance;
  assign data_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!data_stall) begin
      s1_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  cfc_crc_step u_crc_step (
    .crc_in  (crc_register),
    .byte_in (held0),
    .crc_out (crc_fed)
  );

  // Header compare and CRC feed for the beat in the input register.
  always_comb begin
    header_next = header_match;
    unique case (byte_position)
      16'd0:   if (s1_byte != HDR_BYTE0) header_next = 1'b0;
      16'd1:   if (s1_byte != HDR_BYTE1) header_next = 1'b0;
      16'd2:   if (s1_byte != HDR_BYTE2) header_next = 1'b0;
      default: header_next = header_match;
    endcase
    crc_next    = (byte_position >= CRC_START_POS) ? crc_fed : crc_register;
    short_frame = byte_position < MIN_LEN;
  end

  // Frame state update; a last byte returns everything to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register  <= '0;
      held0         <= '0;
      held1         <= '0;
      byte_position <= '0;
      header_match  <= 1'b1;
    end else if (fire) begin
      if (s1_last) begin
        crc_register  <= '0;
        held0         <= '0;
        held1         <= '0;
        byte_position <= '0;
        header_match  <= 1'b1;
      end else begin
        crc_register <= crc_next;
        held0        <= held1;
        held1        <= s1_byte;
        header_match <= header_next;
        if (byte_position != POS_MAX) begin
          byte_position <= byte_position + 16'd1;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && s1_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_last) begin
      too_short    <= short_frame;
      header_ok    <= header_next && (byte_position >= 16'd2);
      computed_crc <= short_frame ? 16'd0 : crc_next;
      crc_ok       <= !short_frame && (held1 == crc_next[7:0]) &&
                      (s1_byte == crc_next[15:8]);
    end
  end

  // A stalled input means both stages are full and the result is held.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> (s1_valid && result_valid && result_stall))
    else $error("input stalled without a blocked result");

  // A processed last byte produces a result in the next cycle.
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    (fire && s1_last) |=> result_valid)
    else $error("last byte gave no result");

  // The frame state is back at reset after a last byte.
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (fire && s1_last) |=> (byte_position == 16'd0 && crc_register == 16'd0 &&
                           header_match))
    else $error("frame state not cleared after last byte");

  // A short frame never reports a CRC.
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (fire && s1_last && short_frame) |=> (!crc_ok && computed_crc == 16'd0))
    else $error("short frame reported a CRC");

endmodule

`default_nettype wire

/* rtl/cfc_crc_step.sv */
// ----------------------------------------------------------------------------
// cfc_crc_step: one byte of the augmented CRC-16 update
// Folds the high byte of the running value through the polynomial, shifts
// the value up by a byte and XORs the new byte into the low byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cfc_crc_step
  import cfc_pkg::*;
(
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  byte_in,
  output logic      [15:0] crc_out
);

  // Eight bit steps of the high-byte fold, then merge with the shifted value.
  always_comb begin
    logic [15:0] acc;
    logic [15:0] hi;
    acc = '0;
    hi  = {crc_in[15:8], 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (((hi ^ acc) & CRC_TOP_BIT) != '0) begin
        acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
      hi = {hi[14:0], 1'b0};
    end
    crc_out = acc ^ {crc_in[7:0], 8'h00} ^ {8'h00, byte_in};
  end

endmodule

`default_nettype wire
